// ----- rtl/core/swsor_pkg.sv -----
// ----------------------------------------------------------------------------
// swsor_pkg: shared constants and types for the sigma outlier filter
// Window geometry, field widths, stream packing and pipeline word types.
// ----------------------------------------------------------------------------
package swsor_pkg;

  // Window geometry
  localparam int WINDOW = 5;
  localparam int HALF   = WINDOW / 2;
  localparam int LAG    = WINDOW - 1 - HALF;
  localparam int NEMIT  = LAG + 1;          // most results one sample can release

  // Field widths
  localparam int TIME_W = 31;
  localparam int VAL_W  = 24;
  localparam int CNT_W  = 16;
  localparam int SEEN_W = $clog2(WINDOW);
  localparam int SEL_W  = (NEMIT > 1) ? $clog2(NEMIT) : 1;

  // Arithmetic widths for the exact spread test
  localparam int DIFF_W = VAL_W + $clog2(WINDOW) + 2;  // WINDOW*v - S, signed
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int ACC_W  = SQ_W + $clog2(WINDOW);

  // Stream packing, whole bytes
  localparam int IN_TDATA_W  = ((TIME_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TIME_W + VAL_W + CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Window contents, index 0 oldest
  typedef logic [WINDOW-1:0][VAL_W-1:0] val_win_t;

  // Per-item control travelling down the pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             check;   // full window: center kept only if not an outlier
    logic [NEMIT-1:0] fixed;   // entries released regardless of the test
  } ctrl_t;

  // Window positions HALF..WINDOW-1, the only ones a result can come from
  typedef struct packed {
    logic [NEMIT-1:0][TIME_W-1:0] t;
    logic [NEMIT-1:0][VAL_W-1:0]  v;
  } snap_t;

endpackage

// ----- rtl/core/sliding_window_sigma_outlier_removal.sv -----
// ----------------------------------------------------------------------------
// sliding_window_sigma_outlier_removal: streaming one-sigma outlier filter
// Centered five-sample window; samples outside mean +/- deviation dropped.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per word, tdata = {value, time}, tlast marks the last
//           sample of a series and flushes the samples still held back.
//   out_* : kept samples in order, tdata = {removed count, value, time},
//           tlast on the last kept sample of the series.
//   A sample leaves once its second right neighbor has arrived (the first two
//   of a series leave at once; the final word releases all held samples).
//   An accepted word reaches out_tvalid through the window, deviation,
//   square and output registers, after any wait in the input skid register
//   when it lands there.
//   Throughput is one word per cycle while out_tready is high; a word
//   releasing n results holds the output register as they go one per cycle.
//   in_tready is the inverted skid flag, so it is registered and never waits
//   on out_tready combinationally. When the receiver stalls the pipeline
//   freezes, one more word lands in the skid register, then in_tready drops.
//   Reset clears the window, series counters, removed count and all valid
//   flags; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module sliding_window_sigma_outlier_removal (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: sample_time[30:0], sample_value[54:31], zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [swsor_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tlast,
  // out_tdata: kept_time[30:0], kept_value[54:31], removed_so_far[70:55], pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [swsor_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast
);
  import swsor_pkg::*;

  // input skid register
  logic                  skid_valid_r;
  logic [IN_TDATA_W-1:0] skid_data_r;
  logic                  skid_last_r;
  logic                  src_valid;
  logic [IN_TDATA_W-1:0] src_data;
  logic                  src_last;
  logic                  take;
  logic                  adv;

  // window and series state
  logic [WINDOW-1:0][VAL_W-1:0]  win_v_r;
  logic [WINDOW-1:0][TIME_W-1:0] win_t_r;
  logic [SEEN_W-1:0]             seen_r;
  logic [CNT_W-1:0]              rc_r;

  // pipeline control and payload
  ctrl_t c1_r, c2_r, c3_r;
  ctrl_t c1_nxt;
  snap_t s1, s2_r, s3_r;
  logic  outlier;

  // output register
  logic [NEMIT-1:0] dmask_r;
  logic             dlast_r;
  logic [CNT_W-1:0] dcnt_r;
  snap_t            dsnap_r;
  logic [NEMIT-1:0] mask_nxt;
  logic [CNT_W-1:0] cnt_item;
  logic [SEL_W-1:0] sel;
  logic             single;

  // source select: skid word has priority
  assign in_tready = !skid_valid_r;
  assign src_valid = skid_valid_r || in_tvalid;
  assign src_data  = skid_valid_r ? skid_data_r : in_tdata;
  assign src_last  = skid_valid_r ? skid_last_r : in_tlast;
  assign take      = adv && src_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (adv) skid_valid_r <= 1'b0;
    end else if (in_tvalid && !adv) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_data_r <= in_tdata;
      skid_last_r <= in_tlast;
    end
  end

  // release plan for the incoming sample
  always_comb begin
    int first_tail;
    int idx;
    idx = int'(seen_r);
    if (idx >= WINDOW - 1)  first_tail = HALF + 1;
    else if (idx >= HALF)   first_tail = WINDOW - 1 - (idx - HALF);
    else                    first_tail = WINDOW;
    c1_nxt.valid = src_valid;
    c1_nxt.last  = src_last;
    c1_nxt.check = (idx >= WINDOW - 1);
    for (int k = 0; k < NEMIT; k++) begin
      c1_nxt.fixed[k] = src_last && (HALF + k >= first_tail);
    end
    if (idx < HALF) c1_nxt.fixed[LAG] = 1'b1;
  end

  // window shift and series position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_v_r <= '0;
      win_t_r <= '0;
      seen_r  <= '0;
    end else if (take) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_v_r[i] <= win_v_r[i+1];
        win_t_r[i] <= win_t_r[i+1];
      end
      win_v_r[WINDOW-1] <= src_data[TIME_W +: VAL_W];
      win_t_r[WINDOW-1] <= src_data[TIME_W-1:0];
      if (src_last) begin
        seen_r <= '0;
      end else if (int'(seen_r) < WINDOW - 1) begin
        seen_r <= seen_r + SEEN_W'(1);
      end
    end
  end

  // snapshot of the positions that can be released
  always_comb begin
    for (int k = 0; k < NEMIT; k++) begin
      s1.t[k] = win_t_r[HALF + k];
      s1.v[k] = win_v_r[HALF + k];
    end
  end

  // control pipeline, frozen while the output register is busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c1_r <= c1_nxt;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s1;
      s3_r <= s2_r;
    end
  end

  swsor_spread u_spread (
    .clk     (clk),
    .en      (adv),
    .win     (win_v_r),
    .outlier (outlier)
  );

  // decision: final release mask and removed count for this sample
  always_comb begin
    mask_nxt = '0;
    cnt_item = rc_r;
    if (c3_r.valid) begin
      mask_nxt = c3_r.fixed;
      if (c3_r.check) begin
        if (outlier) begin
          if (rc_r != CNT_MAX) cnt_item = rc_r + CNT_W'(1);
        end else begin
          mask_nxt[0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= '0;
    end else if (adv && c3_r.valid) begin
      rc_r <= c3_r.last ? '0 : cnt_item;
    end
  end

  // output register: drains the release mask lowest entry first
  always_comb begin
    sel = '0;
    for (int k = NEMIT - 1; k >= 0; k--) begin
      if (dmask_r[k]) sel = SEL_W'(k);
    end
  end

  assign single     = ((dmask_r & (dmask_r - NEMIT'(1))) == '0);
  assign out_tvalid = |dmask_r;
  assign out_tlast  = dlast_r && single;
  assign out_tdata  = OUT_TDATA_W'({dcnt_r, dsnap_r.v[sel], dsnap_r.t[sel]});
  assign adv        = !out_tvalid || (out_tready && single);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmask_r <= '0;
    end else if (adv) begin
      dmask_r <= mask_nxt;
    end else if (out_tready) begin
      dmask_r <= dmask_r & (dmask_r - NEMIT'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlast_r <= c3_r.last;
      dcnt_r  <= cnt_item;
      dsnap_r <= s3_r;
    end
  end

endmodule

// ----- rtl/core/swsor_spread.sv -----
// ----------------------------------------------------------------------------
// swsor_spread: exact one-sigma test over the sample window
// Two register stages: scaled deviations, then squares; the sum of squares
// and the compare against the scaled center term follow the square stage.
// ----------------------------------------------------------------------------
module swsor_spread (
  input  logic                clk,
  input  logic                en,
  input  swsor_pkg::val_win_t win,
  output logic                outlier
);
  import swsor_pkg::*;

  localparam logic signed [DIFF_W-1:0] WIN_S = DIFF_W'(WINDOW);
  localparam logic [ACC_W-1:0]         WIN_A = ACC_W'(WINDOW);

  logic signed [DIFF_W-1:0] sum;
  logic signed [DIFF_W-1:0] diff [WINDOW];
  logic [ABS_W-1:0]         absd_nxt [WINDOW];
  logic [ABS_W-1:0]         absd_r [WINDOW];
  logic [SQ_W-1:0]          sq_r [WINDOW];
  logic [ACC_W-1:0]         spread;
  logic [ACC_W-1:0]         lhs;

  // window sum and |WINDOW*v - S| per sample
  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sum = sum + DIFF_W'($signed(win[i]));
    end
    for (int i = 0; i < WINDOW; i++) begin
      diff[i]     = DIFF_W'($signed(win[i])) * WIN_S - sum;
      absd_nxt[i] = diff[i][DIFF_W-1] ? ABS_W'(-diff[i]) : ABS_W'(diff[i]);
    end
  end

  // deviation and square stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < WINDOW; i++) begin
        absd_r[i] <= absd_nxt[i];
        sq_r[i]   <= absd_r[i] * absd_r[i];
      end
    end
  end

  // drop when WINDOW*d_center^2 exceeds the sum of d^2
  always_comb begin
    spread = '0;
    for (int i = 0; i < WINDOW; i++) begin
      spread = spread + ACC_W'(sq_r[i]);
    end
    lhs     = ACC_W'(sq_r[HALF]) * WIN_A;
    outlier = lhs > spread;
  end

endmodule
